// File: hw/rtl/i2c_memory_master_defines.svh
// ----------------------------------------------------------------------------
// I2C memory master assertion macros
// Assertion helpers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_MEMORY_MASTER_DEFINES_SVH
`define I2C_MEMORY_MASTER_DEFINES_SVH

`ifndef SYNTH
`define I2C_MM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I2C_MM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define I2C_MM_ASSERT(lbl, clk, rst_n, prop, msg)
`define I2C_MM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: hw/rtl/i2c_mm_pkg.sv
// ----------------------------------------------------------------------------
// I2C memory master package
// Item and result types, command codes and bus phase encoding.
// ----------------------------------------------------------------------------
package i2c_mm_pkg;

    localparam logic [2:0] CMD_TICK  = 3'd0;
    localparam logic [2:0] CMD_WRITE = 3'd1;
    localparam logic [2:0] CMD_READ  = 3'd2;
    localparam logic [2:0] CMD_PROBE = 3'd3;
    localparam logic [2:0] CMD_LOAD  = 3'd4;

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_PROBE = 2'd3;

    localparam logic [7:0] DEVICE_BYTE_RESET = 8'hDE;

    typedef enum logic [1:0] {
        KIND_DEVW = 2'd0,
        KIND_ADDR = 2'd1,
        KIND_DEVR = 2'd2,
        KIND_DATA = 2'd3
    } t_kind;

    typedef enum logic [20:0] {
        PH_IDLE      = 21'h000001,
        PH_ST_RELSDA = 21'h000002,
        PH_ST_RELSCL = 21'h000004,
        PH_ST_SDALOW = 21'h000008,
        PH_ST_SCLLOW = 21'h000010,
        PH_TX_DATA   = 21'h000020,
        PH_TX_SCLHI  = 21'h000040,
        PH_TX_SCLLO  = 21'h000080,
        PH_TX_REL    = 21'h000100,
        PH_TX_ACKHI  = 21'h000200,
        PH_TX_ACKLO  = 21'h000400,
        PH_WAIT      = 21'h000800,
        PH_RX_SCLHI  = 21'h001000,
        PH_RX_SCLLO  = 21'h002000,
        PH_MA_SDA    = 21'h004000,
        PH_MA_SCLHI  = 21'h008000,
        PH_MA_SCLLO  = 21'h010000,
        PH_MA_REL    = 21'h020000,
        PH_SP_SDALOW = 21'h040000,
        PH_SP_SCLHI  = 21'h080000,
        PH_SP_SDAHI  = 21'h100000
    } t_phase;

    typedef struct packed {
        logic [2:0]  cmd;
        logic        sda_in;
        logic [7:0]  write_data;
        logic [8:0]  byte_count;
        logic [15:0] mem_address;
    } t_item;

    typedef struct packed {
        logic       done_res;
        logic       busy_res;
        logic       ack_seen;
        logic       want_byte;
        logic       read_valid;
        logic [7:0] read_data;
        logic       sda_low;
        logic       scl_low;
    } t_result;

endpackage

// File: hw/rtl/i2c_mm_in_reg.sv
// ----------------------------------------------------------------------------
// I2C memory master input register
// Holds one accepted item until the engine consumes it.
// ----------------------------------------------------------------------------
module i2c_mm_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  i2c_mm_pkg::t_item  i_item,
    input  logic               i_take,
    output logic               o_valid,
    output i2c_mm_pkg::t_item  o_item
);
    import i2c_mm_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: hw/rtl/i2c_mm_core.sv
// ----------------------------------------------------------------------------
// I2C memory master engine
// Bus phase sequencer: one phase step or command per item, with its result.
// ----------------------------------------------------------------------------
module i2c_mm_core #(
    parameter int MAX_BYTES     = 256,
    parameter int ADDRESS_BYTES = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [7:0]          i_cfg_wr_data,
    input  logic                i_step,
    input  i2c_mm_pkg::t_item   i_item,
    output i2c_mm_pkg::t_result o_result
);
    import i2c_mm_pkg::*;

    localparam int CNT_W = $clog2(MAX_BYTES + 1);
    localparam int AL_W  = $clog2(ADDRESS_BYTES + 1);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_ZERO  = '0;
    localparam logic [AL_W-1:0]  AL_ONE    = AL_W'(1);
    localparam logic [AL_W-1:0]  AL_ZERO   = '0;
    localparam logic [AL_W-1:0]  AL_START  = AL_W'(ADDRESS_BYTES);

    logic [7:0]       r_device_byte;
    t_phase           r_phase,        n_phase;
    logic [1:0]       r_operation,    n_operation;
    logic [3:0]       r_bit_counter,  n_bit_counter;
    logic [7:0]       r_shift_reg,    n_shift_reg;
    logic [CNT_W-1:0] r_bytes_left,   n_bytes_left;
    logic [15:0]      r_address_hold, n_address_hold;
    logic             r_byte_loaded,  n_byte_loaded;
    logic             r_retry_used,   n_retry_used;
    logic             r_last_ack,     n_last_ack;
    logic             r_scl_drive,    n_scl_drive;
    logic             r_sda_drive,    n_sda_drive;
    logic [AL_W-1:0]  r_addr_left,    n_addr_left;
    t_kind            r_byte_kind,    n_byte_kind;
    logic [7:0]       n_rd;
    logic             n_rv;
    logic             n_done;

    always_comb begin
        logic [31:0]      v_count;
        logic [3:0]       v_bc;
        logic [7:0]       v_sr;
        logic [CNT_W-1:0] v_bl;
        logic [AL_W-1:0]  v_k;
        logic [31:0]      v_ah;

        n_phase        = r_phase;
        n_operation    = r_operation;
        n_bit_counter  = r_bit_counter;
        n_shift_reg    = r_shift_reg;
        n_bytes_left   = r_bytes_left;
        n_address_hold = r_address_hold;
        n_byte_loaded  = r_byte_loaded;
        n_retry_used   = r_retry_used;
        n_last_ack     = r_last_ack;
        n_scl_drive    = r_scl_drive;
        n_sda_drive    = r_sda_drive;
        n_addr_left    = r_addr_left;
        n_byte_kind    = r_byte_kind;
        n_rd           = 8'd0;
        n_rv           = 1'b0;
        n_done         = 1'b0;

        v_count = {23'd0, i_item.byte_count};
        if (v_count == 32'd0) begin
            v_count = 32'd1;
        end
        if (v_count > 32'(MAX_BYTES)) begin
            v_count = 32'(MAX_BYTES);
        end
        v_bc = r_bit_counter + 4'd1;
        v_sr = {r_shift_reg[6:0], i_item.sda_in};
        v_bl = (r_bytes_left != CNT_ZERO) ? (r_bytes_left - CNT_ONE) : CNT_ZERO;
        v_k  = r_addr_left - AL_ONE;
        v_ah = {16'd0, r_address_hold};

        case (i_item.cmd)
            CMD_TICK: begin
                case (r_phase)
                    PH_ST_RELSDA: begin
                        n_sda_drive = 1'b0;
                        n_phase     = PH_ST_RELSCL;
                    end
                    PH_ST_RELSCL: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_ST_SDALOW;
                    end
                    PH_ST_SDALOW: begin
                        n_sda_drive = 1'b1;
                        n_phase     = PH_ST_SCLLOW;
                    end
                    PH_ST_SCLLOW: begin
                        n_scl_drive   = 1'b1;
                        n_bit_counter = 4'd0;
                        n_phase       = PH_TX_DATA;
                        if (r_operation == OP_PROBE || r_addr_left == AL_ZERO) begin
                            n_shift_reg = r_device_byte + 8'd1;
                            n_byte_kind = KIND_DEVR;
                        end else begin
                            n_shift_reg = r_device_byte;
                            n_byte_kind = KIND_DEVW;
                        end
                    end
                    PH_WAIT: begin
                        if (r_byte_loaded) begin
                            n_byte_loaded = 1'b0;
                            n_bit_counter = 4'd0;
                            n_byte_kind   = KIND_DATA;
                            n_sda_drive   = !r_shift_reg[7];
                            n_phase       = PH_TX_SCLHI;
                        end
                    end
                    PH_TX_DATA: begin
                        n_sda_drive = !r_shift_reg[7];
                        n_phase     = PH_TX_SCLHI;
                    end
                    PH_TX_SCLHI: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_TX_SCLLO;
                    end
                    PH_TX_SCLLO: begin
                        n_scl_drive   = 1'b1;
                        n_shift_reg   = {r_shift_reg[6:0], 1'b0};
                        n_bit_counter = v_bc;
                        n_phase       = (v_bc >= 4'd8) ? PH_TX_REL : PH_TX_DATA;
                    end
                    PH_TX_REL: begin
                        n_sda_drive = 1'b0;
                        n_phase     = PH_TX_ACKHI;
                    end
                    PH_TX_ACKHI: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_TX_ACKLO;
                    end
                    PH_TX_ACKLO: begin
                        n_last_ack  = !i_item.sda_in;
                        n_scl_drive = 1'b1;
                        if (r_byte_kind == KIND_DEVR) begin
                            n_shift_reg   = 8'd0;
                            n_bit_counter = 4'd0;
                            n_phase       = PH_RX_SCLHI;
                        end else if (r_byte_kind == KIND_DATA) begin
                            n_bytes_left = v_bl;
                            n_phase      = (v_bl != CNT_ZERO) ? PH_WAIT : PH_SP_SDALOW;
                        end else if (r_addr_left != AL_ZERO) begin
                            n_addr_left   = v_k;
                            n_shift_reg   = 8'(v_ah >> {v_k, 3'b000});
                            n_byte_kind   = KIND_ADDR;
                            n_bit_counter = 4'd0;
                            n_phase       = PH_TX_DATA;
                        end else if (r_operation == OP_READ) begin
                            n_phase = PH_ST_RELSDA;
                        end else begin
                            n_byte_loaded = 1'b0;
                            n_phase       = PH_WAIT;
                        end
                    end
                    PH_RX_SCLHI: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_RX_SCLLO;
                    end
                    PH_RX_SCLLO: begin
                        n_shift_reg   = v_sr;
                        n_scl_drive   = 1'b1;
                        n_bit_counter = v_bc;
                        if (v_bc >= 4'd8) begin
                            if (r_operation == OP_READ) begin
                                n_rd = v_sr;
                                n_rv = 1'b1;
                            end
                            n_bytes_left = v_bl;
                            n_phase      = PH_MA_SDA;
                        end else begin
                            n_phase = PH_RX_SCLHI;
                        end
                    end
                    PH_MA_SDA: begin
                        n_sda_drive = (r_bytes_left != CNT_ZERO);
                        n_phase     = PH_MA_SCLHI;
                    end
                    PH_MA_SCLHI: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_MA_SCLLO;
                    end
                    PH_MA_SCLLO: begin
                        n_scl_drive = 1'b1;
                        n_phase     = PH_MA_REL;
                    end
                    PH_MA_REL: begin
                        n_sda_drive = 1'b0;
                        if (r_bytes_left != CNT_ZERO) begin
                            n_shift_reg   = 8'd0;
                            n_bit_counter = 4'd0;
                            n_phase       = PH_RX_SCLHI;
                        end else begin
                            n_phase = PH_SP_SDALOW;
                        end
                    end
                    PH_SP_SDALOW: begin
                        n_sda_drive = 1'b1;
                        n_phase     = PH_SP_SCLHI;
                    end
                    PH_SP_SCLHI: begin
                        n_scl_drive = 1'b0;
                        n_phase     = PH_SP_SDAHI;
                    end
                    PH_SP_SDAHI: begin
                        n_sda_drive = 1'b0;
                        if (r_operation == OP_PROBE && !r_last_ack && !r_retry_used) begin
                            n_retry_used = 1'b1;
                            n_bytes_left = CNT_ONE;
                            n_phase      = PH_ST_RELSDA;
                        end else begin
                            n_done      = 1'b1;
                            n_operation = OP_NONE;
                            n_phase     = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
            CMD_WRITE, CMD_READ, CMD_PROBE: begin
                if (r_phase == PH_IDLE) begin
                    n_operation   = i_item.cmd[1:0];
                    n_retry_used  = 1'b0;
                    n_byte_loaded = 1'b0;
                    n_bit_counter = 4'd0;
                    n_phase       = PH_ST_RELSDA;
                    if (i_item.cmd == CMD_PROBE) begin
                        n_bytes_left = CNT_ONE;
                        n_addr_left  = AL_ZERO;
                    end else begin
                        n_bytes_left   = v_count[CNT_W-1:0];
                        n_address_hold = i_item.mem_address;
                        n_addr_left    = AL_START;
                    end
                end
            end
            CMD_LOAD: begin
                if (r_phase == PH_WAIT && !r_byte_loaded) begin
                    n_shift_reg   = i_item.write_data;
                    n_byte_loaded = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.scl_low    = n_scl_drive;
        o_result.sda_low    = n_sda_drive;
        o_result.read_data  = n_rd;
        o_result.read_valid = n_rv;
        o_result.want_byte  = (n_phase == PH_WAIT) && !n_byte_loaded;
        o_result.ack_seen   = n_last_ack;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = n_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_byte  <= DEVICE_BYTE_RESET;
            r_phase        <= PH_IDLE;
            r_operation    <= OP_NONE;
            r_bit_counter  <= 4'd0;
            r_shift_reg    <= 8'd0;
            r_bytes_left   <= CNT_ZERO;
            r_address_hold <= 16'd0;
            r_byte_loaded  <= 1'b0;
            r_retry_used   <= 1'b0;
            r_last_ack     <= 1'b0;
            r_scl_drive    <= 1'b0;
            r_sda_drive    <= 1'b0;
            r_addr_left    <= AL_ZERO;
            r_byte_kind    <= KIND_DEVW;
        end else begin
            if (i_cfg_wr_en) begin
                r_device_byte <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_phase        <= n_phase;
                r_operation    <= n_operation;
                r_bit_counter  <= n_bit_counter;
                r_shift_reg    <= n_shift_reg;
                r_bytes_left   <= n_bytes_left;
                r_address_hold <= n_address_hold;
                r_byte_loaded  <= n_byte_loaded;
                r_retry_used   <= n_retry_used;
                r_last_ack     <= n_last_ack;
                r_scl_drive    <= n_scl_drive;
                r_sda_drive    <= n_sda_drive;
                r_addr_left    <= n_addr_left;
                r_byte_kind    <= n_byte_kind;
            end
        end
    end

endmodule

// File: hw/rtl/i2c_memory_master.sv
// ----------------------------------------------------------------------------
// I2C memory master
// Memory transaction engine for an I2C EEPROM with a multi-byte address.
// ----------------------------------------------------------------------------
// Each input item is a command or a tick that moves SCL and SDA by one bus
// phase, and each item yields exactly one result item with the pin drives and
// status. The block takes one item per clock cycle; each result passes through
// the input register, the phase sequencer that acts on the item and the
// result register behind it. While a result waits to be taken the sequencer
// holds, and the input stops once its register is full.
module i2c_memory_master #(
    parameter int MAX_BYTES     = 256,
    parameter int ADDRESS_BYTES = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // mem_address[15:0], byte_count[24:16], write_data[32:25], sda_in[33]
    input  logic [39:0] s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // scl_low[0], sda_low[1], read_data[9:2], read_valid[10], want_byte[11],
    // ack_seen[12], busy_res[13], done_res[14]
    output logic [15:0] m_axis_tdata
);
    import i2c_mm_pkg::*;

    `include "i2c_memory_master_defines.svh"

    t_item   s_item;
    t_item   q_item;
    logic    q_valid;
    logic    advance;
    t_result core_result;
    logic    r_out_valid;
    t_result r_out;

    assign s_item.cmd         = s_axis_tuser;
    assign s_item.sda_in      = s_axis_tdata[33];
    assign s_item.write_data  = s_axis_tdata[32:25];
    assign s_item.byte_count  = s_axis_tdata[24:16];
    assign s_item.mem_address = s_axis_tdata[15:0];

    assign advance = q_valid && (!r_out_valid || m_axis_tready);

    i2c_mm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (s_item),
        .i_take  (advance),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    i2c_mm_core #(
        .MAX_BYTES     (MAX_BYTES),
        .ADDRESS_BYTES (ADDRESS_BYTES)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_item        (q_item),
        .o_result      (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out};

    `I2C_MM_ASSERT(a_read_while_busy, i_clk, i_rst_n, (r_out_valid && r_out.read_valid) |-> r_out.busy_res, "read byte reported outside a transaction")
    `I2C_MM_ASSERT(a_done_idle, i_clk, i_rst_n, (r_out_valid && r_out.done_res) |-> (!r_out.busy_res && !r_out.read_valid), "done reported while still busy")
    `I2C_MM_ASSERT(a_want_busy, i_clk, i_rst_n, (r_out_valid && r_out.want_byte) |-> (r_out.busy_res && !r_out.done_res), "byte request outside a write")
    `I2C_MM_ASSERT_NEXT(a_step_fills, i_clk, i_rst_n, advance, r_out_valid, "processed item left no result")

endmodule
